/* hdl/tfcd_pkg.sv */
// Shared types and constants for the tape FSK zero-crossing demodulator.
// Holds the channel payload structs, configuration register indexes and
// the status structs passed on by the sync and bit assembly units.
`timescale 1ns / 1ps
`default_nettype none

package tfcd_pkg;

    // Fixed field widths
    localparam int WIDTH_BITS = 16;   // crossing width in sample counts
    localparam int SUM_W      = 32;   // header width accumulator
    localparam int FRAC_W     = 8;    // short threshold, 1/256 units
    localparam int PHASE_W    = 4;    // phase and marker counters
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register reset values
    localparam logic [FRAC_W-1:0]  SHORT_FRACTION_RST   = 8'd160;
    localparam logic [PHASE_W-1:0] SOD_PHASES_RST       = 4'd0;
    localparam logic [PHASE_W-1:0] LONG_BIT_PHASES_RST  = 4'd2;
    localparam logic [PHASE_W-1:0] SHORT_BIT_PHASES_RST = 4'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_FRACTION   = 2'd0,
        CFG_SOD_PHASES       = 2'd1,
        CFG_LONG_BIT_PHASES  = 2'd2,
        CFG_SHORT_BIT_PHASES = 2'd3
    } cfg_index_t;

    // Header tracking state while searching
    typedef enum logic [2:0] {
        HDR_SKIP  = 3'b001,   // drop the next crossing
        HDR_FIRST = 3'b010,   // first valid width, counted twice
        HDR_ACCUM = 3'b100    // averaging header, looking for marker
    } hdr_state_t;

    // Input transaction payload
    typedef struct packed {
        logic                  restart;
        logic [WIDTH_BITS-1:0] crossing_width;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic bit_valid;
        logic out_bit;
        logic bad_bit;
        logic locked;
    } out_item_t;

    // Sync unit to bit assembler
    typedef struct packed {
        logic active;      // locked after this crossing, decode it
        logic width_long;  // crossing is not short
    } sync_info_t;

    // Bit assembler result
    typedef struct packed {
        logic bit_valid;
        logic out_bit;
        logic bad_bit;
    } bit_result_t;

endpackage

`default_nettype wire

/* hdl/tfcd_sync.sv */
// Header averaging, short/long classification and start-of-data lock.
// Depends on tfcd_pkg for widths, header state encoding and sync_info_t.
`timescale 1ns / 1ps
`default_nettype none

module tfcd_sync #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            proc_en,
    input  wire logic                            restart,
    input  wire logic [tfcd_pkg::WIDTH_BITS-1:0] crossing_width,
    input  wire logic [tfcd_pkg::FRAC_W-1:0]     short_fraction,
    input  wire logic [tfcd_pkg::PHASE_W-1:0]    lock_run,
    output tfcd_pkg::sync_info_t                 sync_info
);
    import tfcd_pkg::*;

    localparam int PA_W  = WIDTH_BITS + COUNT_BITS;
    localparam int PB_W  = SUM_W + FRAC_W;
    localparam int CMP_W = (PA_W + 8 > PB_W) ? PA_W + 8 : PB_W;

    logic                  sync_locked_reg, sync_locked_next;
    hdr_state_t            hdr_state_reg, hdr_state_next;
    logic [SUM_W-1:0]      width_sum_reg, width_sum_next;
    logic [COUNT_BITS-1:0] width_count_reg, width_count_next;
    logic [PHASE_W-1:0]    marker_count_reg, marker_count_next;

    logic [PA_W-1:0]  prod_width;
    logic [PB_W-1:0]  prod_thresh;
    logic             is_short;
    logic [SUM_W:0]   sum_ext;
    logic             acc_room;
    logic [PHASE_W-1:0] marker_inc;

    // Short test: width*count*256 < sum*fraction, exact integer compare
    assign prod_width  = PA_W'(crossing_width) * PA_W'(width_count_reg);
    assign prod_thresh = PB_W'(width_sum_reg) * PB_W'(short_fraction);
    assign is_short    = (CMP_W'(prod_width) << 8) < CMP_W'(prod_thresh);

    // Accumulator saturation checks
    assign sum_ext  = {1'b0, width_sum_reg} + (SUM_W+1)'(crossing_width);
    assign acc_room = (width_count_reg != {COUNT_BITS{1'b1}}) && !sum_ext[SUM_W];
    assign marker_inc = (marker_count_reg != {PHASE_W{1'b1}}) ?
                        marker_count_reg + 1'b1 : marker_count_reg;

    // Next-state logic for the search / lock sequence
    always_comb begin
        sync_locked_next  = sync_locked_reg;
        hdr_state_next    = hdr_state_reg;
        width_sum_next    = width_sum_reg;
        width_count_next  = width_count_reg;
        marker_count_next = marker_count_reg;
        if (restart) begin
            sync_locked_next  = 1'b0;
            hdr_state_next    = HDR_SKIP;
            width_sum_next    = '0;
            width_count_next  = '0;
            marker_count_next = '0;
        end else if (!sync_locked_reg) begin
            unique case (hdr_state_reg)
                HDR_SKIP: begin
                    hdr_state_next   = HDR_FIRST;
                    width_sum_next   = '0;
                    width_count_next = '0;
                end
                HDR_FIRST: begin
                    // first width counts twice; never short against itself
                    hdr_state_next    = HDR_ACCUM;
                    width_sum_next    = SUM_W'(crossing_width) << 1;
                    width_count_next  = COUNT_BITS'(2);
                    marker_count_next = '0;
                end
                HDR_ACCUM: begin
                    if (is_short) begin
                        marker_count_next = marker_inc;
                        if (marker_inc >= lock_run) begin
                            sync_locked_next = 1'b1;
                        end
                    end else begin
                        if (acc_room) begin
                            width_sum_next   = sum_ext[SUM_W-1:0];
                            width_count_next = width_count_reg + 1'b1;
                        end
                        marker_count_next = '0;
                    end
                end
                default: begin
                    hdr_state_next = HDR_SKIP;
                end
            endcase
        end
    end

    assign sync_info.active     = sync_locked_next && !restart;
    assign sync_info.width_long = !is_short;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_locked_reg  <= 1'b0;
            hdr_state_reg    <= HDR_SKIP;
            width_sum_reg    <= '0;
            width_count_reg  <= '0;
            marker_count_reg <= '0;
        end else if (proc_en) begin
            sync_locked_reg  <= sync_locked_next;
            hdr_state_reg    <= hdr_state_next;
            width_sum_reg    <= width_sum_next;
            width_count_reg  <= width_count_next;
            marker_count_reg <= marker_count_next;
        end
    end

    // Lock is only reached from header accumulation
    a_lock_in_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        sync_locked_reg |-> hdr_state_reg == HDR_ACCUM)
        else $error("locked outside header accumulation");

    // Accumulating header always holds at least the doubled first width
    a_count_min: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_state_reg == HDR_ACCUM |-> width_count_reg >= COUNT_BITS'(2))
        else $error("header count below two while accumulating");

    // Lock is held until a restart is processed
    a_lock_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        sync_locked_reg && !(proc_en && restart) |=> sync_locked_reg)
        else $error("lock dropped without restart");

endmodule

`default_nettype wire

/* hdl/tfcd_bitasm.sv */
// Phase counter that groups classified crossings into data bits.
// Depends on tfcd_pkg for sync_info_t, bit_result_t and widths.
`timescale 1ns / 1ps
`default_nettype none

module tfcd_bitasm (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         proc_en,
    input  wire logic                         restart,
    input  wire tfcd_pkg::sync_info_t         sync_info,
    input  wire logic [tfcd_pkg::PHASE_W-1:0] one_span,
    input  wire logic [tfcd_pkg::PHASE_W-1:0] zero_span,
    output tfcd_pkg::bit_result_t             bit_result
);
    import tfcd_pkg::*;

    logic [PHASE_W-1:0] phase_count_reg, phase_count_next;
    logic               cur_bit_reg, cur_bit_next;

    logic               cur_bit_eff;
    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] end_sel;
    logic [PHASE_W-1:0] end_phase;

    // Bit value is taken from the first phase of each bit
    assign cur_bit_eff = (phase_count_reg == '0) ? sync_info.width_long : cur_bit_reg;
    assign phase_inc   = phase_count_reg + 1'b1;
    assign end_sel     = cur_bit_eff ? one_span : zero_span;
    assign end_phase   = (end_sel == '0) ? PHASE_W'(1) : end_sel;

    // Mismatch aborts, reaching the phase count completes the bit
    always_comb begin
        phase_count_next     = phase_count_reg;
        cur_bit_next         = cur_bit_reg;
        bit_result.bit_valid = 1'b0;
        bit_result.out_bit   = 1'b0;
        bit_result.bad_bit   = 1'b0;
        if (restart) begin
            phase_count_next = '0;
            cur_bit_next     = 1'b0;
        end else if (sync_info.active) begin
            if (phase_inc <= end_phase && sync_info.width_long != cur_bit_eff) begin
                bit_result.bad_bit = 1'b1;
                phase_count_next   = '0;
                cur_bit_next       = 1'b1;
            end else if (phase_inc == end_phase) begin
                bit_result.bit_valid = 1'b1;
                bit_result.out_bit   = cur_bit_eff;
                phase_count_next     = '0;
                cur_bit_next         = 1'b1;
            end else begin
                phase_count_next = phase_inc;
                cur_bit_next     = cur_bit_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_reg <= '0;
            cur_bit_reg     <= 1'b0;
        end else if (proc_en) begin
            phase_count_reg <= phase_count_next;
            cur_bit_reg     <= cur_bit_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/tape_fsk_crossing_demodulator.sv */
// Tape FSK zero-crossing demodulator top level: channel registers, config.
// Depends on tfcd_pkg, tfcd_sync and tfcd_bitasm.
//
// Usage: each s_ transaction carries one crossing width (time between two
// zero crossings) or a restart request. Every accepted transaction produces
// exactly one m_ transaction with bit_valid, out_bit, bad_bit and locked.
// While searching, the first width is dropped, header widths are averaged
// and a run of short widths (marker length register) locks the decoder;
// once locked, groups of equal phases become bits until a restart arrives.
// Configuration registers are written through cfg_wr_* while the block is
// idle; they take effect on the next crossing.
// A transaction goes into the input register and is processed into the
// output register once that register is free or draining; m_valid is
// driven by the output register. Throughput: one transaction per cycle
// while m_ready is high or the output register is empty; the classify
// multiply-compare and the next-state logic are combinational.
// Reset (aresetn low, synchronous) empties both registers, returns to the
// searching state and loads the configuration reset values.
// When m_ready is low the result is held; one more input is taken into the
// input register, after which s_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module tape_fsk_crossing_demodulator #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tfcd_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output tfcd_pkg::out_item_t                  m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tfcd_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [tfcd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import tfcd_pkg::*;

    logic               in_valid_reg, in_valid_next;
    in_item_t           in_data_reg;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;
    logic [FRAC_W-1:0]  short_fraction_reg;
    logic [PHASE_W-1:0] lock_run_reg;
    logic [PHASE_W-1:0] one_span_reg;
    logic [PHASE_W-1:0] zero_span_reg;

    logic        s_accept;
    logic        proc_en;
    sync_info_t  sync_info;
    bit_result_t bit_result;

    // Handshake: process when the output register is free or draining
    assign proc_en  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || proc_en;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_en) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_en) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Result assembly; a restart gives an all-zero result
    always_comb begin
        out_data_next.bit_valid = bit_result.bit_valid;
        out_data_next.out_bit   = bit_result.out_bit;
        out_data_next.bad_bit   = bit_result.bad_bit;
        out_data_next.locked    = sync_info.active;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
        if (proc_en) begin
            out_data_reg <= out_data_next;
        end
    end

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_fraction_reg <= SHORT_FRACTION_RST;
            lock_run_reg       <= SOD_PHASES_RST;
            one_span_reg       <= LONG_BIT_PHASES_RST;
            zero_span_reg      <= SHORT_BIT_PHASES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_SHORT_FRACTION:   short_fraction_reg <= cfg_wr_data;
                CFG_SOD_PHASES:       lock_run_reg       <= cfg_wr_data[PHASE_W-1:0];
                CFG_LONG_BIT_PHASES:  one_span_reg       <= cfg_wr_data[PHASE_W-1:0];
                CFG_SHORT_BIT_PHASES: zero_span_reg      <= cfg_wr_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    tfcd_sync #(
        .COUNT_BITS (COUNT_BITS)
    ) u_sync (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .proc_en        (proc_en),
        .restart        (in_data_reg.restart),
        .crossing_width (in_data_reg.crossing_width),
        .short_fraction (short_fraction_reg),
        .lock_run       (lock_run_reg),
        .sync_info      (sync_info)
    );

    tfcd_bitasm u_bitasm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .proc_en    (proc_en),
        .restart    (in_data_reg.restart),
        .sync_info  (sync_info),
        .one_span   (one_span_reg),
        .zero_span  (zero_span_reg),
        .bit_result (bit_result)
    );

    // A completed bit and an aborted bit never share a result
    a_valid_xor_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.bit_valid && m_data.bad_bit))
        else $error("bit_valid and bad_bit both set");

    // Bits are only produced while locked
    a_bits_need_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.bit_valid || m_data.bad_bit) |-> m_data.locked)
        else $error("bit activity without lock");

    // A processed restart gives an all-zero result
    a_restart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && in_data_reg.restart |=> m_valid && m_data == '0)
        else $error("restart result not all zero");

endmodule

`default_nettype wire

/* tb/sv/tb_tape_fsk_crossing_demodulator.sv */
// Self-checking testbench for the tape FSK zero-crossing demodulator.
// Drives crossing widths and register writes, predicts every status transaction.
// Depends on tfcd_pkg and tape_fsk_crossing_demodulator.
`timescale 1ns / 1ps

module tb_tape_fsk_crossing_demodulator;

    import tfcd_pkg::*;

    localparam int          DUT_COUNT_BITS = 16;
    localparam int          IN_W           = $bits(in_item_t);
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] COUNT_MAX      = (64'd1 << DUT_COUNT_BITS) - 64'd1;
    localparam logic [63:0] SUM_MAX        = 64'hFFFF_FFFF;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Register shadow copies
    logic [FRAC_W-1:0]  reg_frac;
    logic [PHASE_W-1:0] reg_sod;
    logic [PHASE_W-1:0] reg_long;
    logic [PHASE_W-1:0] reg_short;

    // Demodulator state tracked alongside the block
    logic               trk_locked;
    hdr_state_t         trk_hdr;
    logic [63:0]        trk_sum;
    logic [63:0]        trk_count;
    logic [PHASE_W-1:0] trk_marker;
    logic [PHASE_W-1:0] trk_phase;
    logic               trk_bitval;

    out_item_t predicted_status_q[$];
    int        items_sent    = 0;
    int        fail_count    = 0;
    int        idle_cycles   = 0;
    int        src_idle_pct  = 0;
    int        snk_stall_pct = 0;

    tape_fsk_crossing_demodulator #(
        .COUNT_BITS(DUT_COUNT_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void clear_tracker();
        trk_locked = 1'b0;
        trk_hdr    = HDR_SKIP;
        trk_sum    = '0;
        trk_count  = '0;
        trk_marker = '0;
        trk_phase  = '0;
        trk_bitval = 1'b0;
    endfunction

    // Short when width is under fraction/256 of the header mean, cross-multiplied
    function automatic logic width_is_short(logic [WIDTH_BITS-1:0] w);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = 64'(w) * trk_count * 64'd256;
        rhs = trk_sum * 64'(reg_frac);
        return lhs < rhs;
    endfunction

    function automatic out_item_t predict_crossing(in_item_t item);
        out_item_t             res;
        logic [WIDTH_BITS-1:0] w;
        logic                  symbol;
        logic [PHASE_W-1:0]    end_phase;
        res = '0;
        w   = item.crossing_width;
        if (item.restart) begin
            clear_tracker();
            return res;
        end
        // Header averaging and start-of-data search
        if (!trk_locked) begin
            if (trk_hdr == HDR_SKIP) begin
                trk_hdr   = HDR_FIRST;
                trk_sum   = '0;
                trk_count = '0;
                return res;
            end
            if (trk_hdr == HDR_FIRST) begin
                trk_sum   = 64'(w);
                trk_count = 64'd1;
                trk_hdr   = HDR_ACCUM;
            end
            if (width_is_short(w)) begin
                if (trk_marker != 4'd15) trk_marker++;
                if (trk_marker >= reg_sod) trk_locked = 1'b1;
            end else begin
                if (trk_count < COUNT_MAX && trk_sum + 64'(w) <= SUM_MAX) begin
                    trk_sum   = trk_sum + 64'(w);
                    trk_count = trk_count + 64'd1;
                end
                trk_marker = '0;
            end
        end
        // Bit assembly from runs of equal phases
        if (trk_locked) begin
            symbol = !width_is_short(w);
            if (trk_phase == 0) trk_bitval = symbol;
            trk_phase = trk_phase + 4'd1;
            end_phase = trk_bitval ? reg_long : reg_short;
            if (end_phase == 0) end_phase = 4'd1;
            if (trk_phase <= end_phase && symbol != trk_bitval) begin
                res.bad_bit = 1'b1;
                trk_phase   = '0;
                trk_bitval  = 1'b1;
            end else if (trk_phase == end_phase) begin
                res.bit_valid = 1'b1;
                res.out_bit   = trk_bitval;
                trk_phase     = '0;
                trk_bitval    = 1'b1;
            end
        end
        res.locked = trk_locked;
        return res;
    endfunction

    function automatic logic [WIDTH_BITS-1:0] wide_gap(int period);
        return WIDTH_BITS'(period + $urandom_range(period / 8));
    endfunction

    function automatic logic [WIDTH_BITS-1:0] short_width(int period);
        return WIDTH_BITS'(period / 2 - $urandom_range(period / 16));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus primitives (called at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_crossing(input logic restart_req, input logic [WIDTH_BITS-1:0] width);
        in_item_t item;
        item.restart        = restart_req;
        item.crossing_width = width;
        while ($urandom_range(99) < src_idle_pct) begin
            s_data = in_item_t'(IN_W'($urandom));
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        predicted_status_q.push_back(predict_crossing(item));
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_SHORT_FRACTION:   reg_frac  = value;
            CFG_SOD_PHASES:       reg_sod   = value[PHASE_W-1:0];
            CFG_LONG_BIT_PHASES:  reg_long  = value[PHASE_W-1:0];
            CFG_SHORT_BIT_PHASES: reg_short = value[PHASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_results_drained();
        while (predicted_status_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset defaults: skip, doubled first width, zero mean, lock, bits, bad bits
    task automatic test_default_decode();
        src_idle_pct  = 9;
        snk_stall_pct = 9;
        send_crossing(1'b0, 16'hFFFF);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd1200);
        send_crossing(1'b1, 16'hFFFF);
        send_crossing(1'b0, 16'd0);
        // zero first width gives a zero mean, nothing can be short
        send_crossing(1'b0, 16'd0);
        send_crossing(1'b0, 16'd0);
        send_crossing(1'b0, 16'd1);
        send_crossing(1'b1, 16'd0);
        send_crossing(1'b0, 16'd1234);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd600);
        send_crossing(1'b0, 16'd600);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd600);
        send_crossing(1'b0, 16'hFFFF);
        send_crossing(1'b0, 16'd0);
        send_crossing(1'b0, 16'hFFFF);
        send_crossing(1'b0, 16'hFFFF);
        send_crossing(1'b1, 16'h5555);
    endtask

    // Register extremes: marker saturation, zero phase registers, zero and
    // smallest fraction, longest bits
    task automatic test_register_extremes();
        src_idle_pct  = 68;
        snk_stall_pct = 0;
        wait_results_drained();
        write_register(CFG_SHORT_FRACTION, 8'd255);
        write_register(CFG_SOD_PHASES, {4'($urandom), 4'd15});
        write_register(CFG_LONG_BIT_PHASES, {4'($urandom), 4'd0});
        write_register(CFG_SHORT_BIT_PHASES, {4'($urandom), 4'd0});
        send_crossing(1'b1, 16'd0);
        send_crossing(1'b0, 16'hFFFF);
        repeat (4) send_crossing(1'b0, 16'd1000);
        repeat (20) send_crossing(1'b0, 16'd900);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd900);
        send_crossing(1'b0, 16'hFFFF);
        send_crossing(1'b0, 16'd0);

        // zero fraction never locks
        wait_results_drained();
        write_register(CFG_SHORT_FRACTION, 8'd0);
        write_register(CFG_SOD_PHASES, 8'd0);
        send_crossing(1'b1, 16'd1);
        send_crossing(1'b0, 16'd5);
        send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd0);
        repeat (6) send_crossing(1'b0, 16'($urandom_range(1000)));

        // smallest fraction, fifteen phases per bit
        wait_results_drained();
        write_register(CFG_SHORT_FRACTION, 8'd1);
        write_register(CFG_LONG_BIT_PHASES, 8'd15);
        write_register(CFG_SHORT_BIT_PHASES, 8'd15);
        send_crossing(1'b1, 16'hAAAA);
        send_crossing(1'b0, 16'd7);
        repeat (3) send_crossing(1'b0, 16'd40000);
        send_crossing(1'b0, 16'd0);
        repeat (14) send_crossing(1'b0, 16'($urandom_range(100)));
        repeat (15) send_crossing(1'b0, 16'd40000);
        repeat (7) send_crossing(1'b0, 16'd40000);
        send_crossing(1'b0, 16'd3);
    endtask

    // Long header average with short bursts below the lock count, then a lock after register writes
    task automatic test_header_averaging();
        int n;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        wait_results_drained();
        write_register(CFG_SHORT_FRACTION, 8'd1);
        write_register(CFG_SOD_PHASES, 8'd15);
        send_crossing(1'b1, 16'hFFFF);
        send_crossing(1'b0, 16'd1500);
        for (n = 0; n < 100; n++) begin
            // short bursts stay below the lock threshold; the next long width clears the marker count
            if (n % 25 == 10)
                repeat ($urandom_range(14, 1)) send_crossing(1'b0, 16'($urandom_range(3)));
            send_crossing(1'b0, 16'($urandom_range(2000, 1000)));
        end
        // a long width clears the marker
        repeat (10) send_crossing(1'b0, 16'd1);
        send_crossing(1'b0, 16'd1500);
        repeat (10) send_crossing(1'b0, 16'd2);
        wait_results_drained();
        write_register(CFG_SHORT_FRACTION, 8'd255);
        write_register(CFG_SOD_PHASES, 8'd2);
        write_register(CFG_LONG_BIT_PHASES, 8'd2);
        write_register(CFG_SHORT_BIT_PHASES, 8'd1);
        send_crossing(1'b0, 16'd2000);
        repeat (3) send_crossing(1'b0, 16'd1000);
        send_crossing(1'b0, 16'd2000);
        send_crossing(1'b0, 16'd2000);
        send_crossing(1'b0, 16'd700);
    endtask

    // Random tape blocks: restart, header, marker, data bits, noise
    task automatic test_random_streams();
        int   phase_idx;
        int   stop_at;
        int   pause_at;
        int   period;
        int   marker_len;
        int   bit_len;
        int   n;
        int   sel;
        logic symbol;
        logic flip;
        logic paused;
        for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
            wait_results_drained();
            case (phase_idx)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
                default: begin src_idle_pct = 9; snk_stall_pct = 9; end
            endcase
            write_register(CFG_SHORT_FRACTION, 8'($urandom_range(200, 128)));
            write_register(CFG_SOD_PHASES, 8'($urandom));
            write_register(CFG_LONG_BIT_PHASES, {4'($urandom), 4'($urandom_range(6))});
            write_register(CFG_SHORT_BIT_PHASES, {4'($urandom), 4'($urandom_range(6))});
            stop_at  = items_sent + 250;
            pause_at = items_sent + 125;
            paused   = 1'b0;
            while (items_sent < stop_at) begin
                sel    = $urandom_range(99);
                period = ($urandom_range(9) == 0) ? $urandom_range(58000, 30000)
                                                  : $urandom_range(4000, 40);
                if (sel < 10) begin
                    repeat ($urandom_range(20, 1))
                        send_crossing($urandom_range(15) == 0, 16'($urandom));
                end else begin
                    // a few blocks continue from the current state
                    if (sel >= 15) begin
                        send_crossing(1'b1, 16'($urandom));
                        send_crossing(1'b0, 16'($urandom));
                    end
                    repeat ($urandom_range(30, 2)) send_crossing(1'b0, wide_gap(period));
                    // some markers end too early
                    marker_len = (sel < 30) ? $urandom_range(reg_sod)
                                            : reg_sod + $urandom_range(2);
                    repeat (marker_len) send_crossing(1'b0, short_width(period));
                    repeat ($urandom_range(20, 2)) begin
                        symbol  = 1'($urandom_range(1));
                        bit_len = symbol ? reg_long : reg_short;
                        if (bit_len == 0) bit_len = 1;
                        for (n = 0; n < bit_len; n++) begin
                            flip = ($urandom_range(39) == 0);
                            send_crossing(1'b0, (symbol ^ flip) ? wide_gap(period)
                                                                : short_width(period));
                        end
                    end
                end
                // sender holds off once per phase until the pipeline is empty
                if (!paused && items_sent >= pause_at) begin
                    wait_results_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------
    always @(negedge aclk) m_ready = ($urandom_range(99) >= snk_stall_pct);

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s mismatch: expected %0b, actual %0b", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_status_q.size() == 0) begin
                $error("unexpected result transaction: %b", m_data);
                fail_count++;
            end else begin
                want = predicted_status_q.pop_front();
                check_field("bit_valid", want.bit_valid, m_data.bit_valid);
                check_field("out_bit", want.out_bit, m_data.out_bit);
                check_field("bad_bit", want.bad_bit, m_data.bad_bit);
                check_field("locked", want.locked, m_data.locked);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = CFG_SHORT_FRACTION;
        cfg_wr_data  = '0;
        reg_frac     = SHORT_FRACTION_RST;
        reg_sod      = SOD_PHASES_RST;
        reg_long     = LONG_BIT_PHASES_RST;
        reg_short    = SHORT_BIT_PHASES_RST;
        clear_tracker();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_decode();
        test_register_extremes();
        test_header_averaging();
        test_random_streams();

        wait_results_drained();
        repeat (5) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* tape_fsk_crossing_demodulator.f */
hdl/tfcd_pkg.sv
hdl/tfcd_sync.sv
hdl/tfcd_bitasm.sv
hdl/tape_fsk_crossing_demodulator.sv
tb/sv/tb_tape_fsk_crossing_demodulator.sv
